/* rtl/core/assert_macros.svh */
// Assertion macros for the buzzer sequencer RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bps_pkg.sv */
// Package for the buzzer pattern sequencer: widths, defaults and the envelope ROM.
`timescale 1ns / 1ps

package bps_pkg;

  localparam int STEP_COUNT_DEF  = 10;
  localparam int MAX_REPEATS_DEF = 24;

  localparam int TIME_W = 32;
  localparam int REP_W  = 8;
  localparam int POS_W  = 4;   // ROM has 16 slots
  localparam int SPAN_W = 10;  // longest step is 568 ms
  localparam int OP_W   = 2;

  localparam int IN_DATA_W  = 40;  // time_ms, repeat_request
  localparam int IN_USER_W  = 2;   // opcode
  localparam int OUT_DATA_W = 8;   // buzzer_on, is_playing, start_accepted

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  function automatic logic [SPAN_W-1:0] step_span(input logic [POS_W-1:0] idx);
    logic [SPAN_W-1:0] s;
    case (idx)
      4'd0:    s = 10'd110;
      4'd1:    s = 10'd30;
      4'd2:    s = 10'd150;
      4'd3:    s = 10'd10;
      4'd4:    s = 10'd140;
      4'd5:    s = 10'd60;
      4'd6:    s = 10'd170;
      4'd7:    s = 10'd12;
      4'd8:    s = 10'd280;
      4'd9:    s = 10'd568;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic step_level(input logic [POS_W-1:0] idx);
    logic l;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd8: l = 1'b1;
      default:                      l = 1'b0;
    endcase
    return l;
  endfunction

endpackage

/* rtl/core/buzzer_pattern_sequencer_top.sv */
// Buzzer pattern sequencer: top level with command sequencer and shared 32-bit adder.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Plays a ten-step on/off envelope, repeated 1..MAX_REPEATS times. Each input
// word carries a command in s_tuser (tick, start, stop, or the unused code 3)
// and a millisecond time plus a repeat count in s_tdata. Every word gives
// exactly one output word with the buzzer level, the playing flag and a
// start-accepted flag. Start, stop, a tick while idle and the unused code go
// from ST_IDLE straight to ST_EMIT. A tick while playing passes through
// ST_CALC, and through ST_STEP and ST_CALC again for each envelope step it
// catches up on, because one 32-bit adder/subtractor does both the deadline
// compare and the deadline update in turn. The block takes no new word until
// the current result has been loaded into the output register. That register
// may still be waiting on m_tready when the next word is accepted, and a
// result that finds it full waits for it, which adds those stall cycles to the
// item. s_tready is low during reset. Deadlines compare by the sign of
// (time_ms - deadline) modulo 2^32, so time wrap is harmless.
module buzzer_pattern_sequencer_top #(
  parameter int STEP_COUNT  = bps_pkg::STEP_COUNT_DEF,   // 1..16
  parameter int MAX_REPEATS = bps_pkg::MAX_REPEATS_DEF   // 1..255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] time_ms, [39:32] repeat_request
  input  logic [bps_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] opcode
  input  logic [bps_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] buzzer_on, [1] is_playing, [2] start_accepted, [7:3] zero
  output logic [bps_pkg::OUT_DATA_W-1:0] m_tdata
);
  import bps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a word
    ST_CALC = 4'b0010,  // adder: time - deadline
    ST_STEP = 4'b0100,  // adder: deadline + next span
    ST_EMIT = 4'b1000   // load output register
  } state_t;

  state_t state;

  // Sequencer state
  logic              playing;
  logic [POS_W-1:0]  step_position;
  logic [REP_W-1:0]  repeats_done;
  logic [REP_W-1:0]  repeats_wanted;
  logic [TIME_W-1:0] next_deadline;
  logic              drive_level;
  logic              accepted;

  // Latched time of the current tick
  logic [TIME_W-1:0] now_r;

  logic              accept;
  opcode_t           op_in;
  logic [TIME_W-1:0] time_in;
  logic [REP_W-1:0]  req_in;
  logic              req_ok;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = !rst && (state == ST_IDLE);
  assign op_in   = opcode_t'(s_tuser[OP_W-1:0]);
  assign time_in = s_tdata[TIME_W-1:0];
  assign req_in  = s_tdata[TIME_W +: REP_W];
  assign req_ok  = (req_in != '0) && (req_in <= REP_W'(MAX_REPEATS));

  // Step advance decode
  logic [POS_W:0]    pos_inc;
  logic              wrap;
  logic [REP_W-1:0]  rep_inc;
  logic              phrase_end;
  logic [POS_W-1:0]  pos_next;

  assign pos_inc    = {1'b0, step_position} + (POS_W+1)'(1);
  assign wrap       = pos_inc >= (POS_W+1)'(STEP_COUNT);
  assign rep_inc    = repeats_done + REP_W'(1);
  assign phrase_end = wrap && (rep_inc >= repeats_wanted);
  assign pos_next   = wrap ? '0 : pos_inc[POS_W-1:0];

  // Shared adder/subtractor
  logic [TIME_W-1:0] add_a, add_b, add_sum;
  logic              add_sub;

  always_comb begin
    add_a   = next_deadline;
    add_b   = TIME_W'(step_span(pos_next));
    add_sub = 1'b0;
    case (state)
      ST_IDLE: begin
        add_a = time_in;
        add_b = TIME_W'(step_span('0));
      end
      ST_CALC: begin
        add_a   = now_r;
        add_b   = next_deadline;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + TIME_W'(add_sub);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      playing        <= 1'b0;
      step_position  <= '0;
      repeats_done   <= '0;
      repeats_wanted <= '0;
      next_deadline  <= '0;
      drive_level    <= 1'b0;
      accepted       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            accepted <= 1'b0;
            now_r    <= time_in;
            state    <= ST_EMIT;
            case (op_in)
              OP_TICK: begin
                if (playing) begin
                  state <= ST_CALC;
                end
              end
              OP_START: begin
                if (req_ok) begin
                  step_position  <= '0;
                  repeats_done   <= '0;
                  repeats_wanted <= req_in;
                  playing        <= 1'b1;
                  drive_level    <= step_level('0);
                  next_deadline  <= add_sum;
                  accepted       <= 1'b1;
                end
              end
              OP_STOP: begin
                playing        <= 1'b0;
                step_position  <= '0;
                repeats_done   <= '0;
                repeats_wanted <= '0;
                next_deadline  <= '0;
                drive_level    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_CALC: begin
          // sign bit clear: deadline reached
          state <= add_sum[TIME_W-1] ? ST_EMIT : ST_STEP;
        end
        ST_STEP: begin
          if (phrase_end) begin
            playing        <= 1'b0;
            step_position  <= '0;
            repeats_done   <= '0;
            repeats_wanted <= '0;
            next_deadline  <= '0;
            drive_level    <= 1'b0;
            state          <= ST_EMIT;
          end else begin
            if (wrap) begin
              repeats_done <= rep_inc;
            end
            step_position <= pos_next;
            drive_level   <= step_level(pos_next);
            next_deadline <= add_sum;
            state         <= ST_CALC;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output valid: set when a result is loaded, cleared once it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {5'b0, accepted, playing, drive_level};
    end
  end

  `BPS_ASSERT(a_idle_clean, !playing |-> (step_position == '0 && !drive_level), "idle but step state not cleared")
  `BPS_ASSERT(a_rep_bound, playing |-> (repeats_done < repeats_wanted), "repeat count overran request")
  `BPS_ASSERT(a_one_word, (s_tvalid && s_tready) |=> !s_tready, "second word taken while busy")
  `BPS_ASSERT(a_emit_src, $rose(m_tvalid) |-> $past(state == ST_EMIT), "output valid raised outside emit")

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the buzzer pattern sequencer top level.
`timescale 1ns / 1ps

module tb_top;
  import bps_pkg::*;

  localparam int ENV_STEPS = STEP_COUNT_DEF;
  localparam int REP_LIMIT = MAX_REPEATS_DEF;

  // envelope durations and levels, one per ROM slot; slots past ten are silent
  localparam logic [9:0] ENV_SPAN [0:15] = '{
    10'd110, 10'd30, 10'd150, 10'd10, 10'd140, 10'd60, 10'd170, 10'd12,
    10'd280, 10'd568, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };
  localparam logic [15:0] ENV_LEVEL = 16'h0155;

  typedef struct packed {
    logic buzzer_on;
    logic is_playing;
    logic start_accepted;
  } buzz_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predicted sequencer state
  logic        seq_playing;
  logic [3:0]  seq_step;
  logic [7:0]  seq_done;
  logic [7:0]  seq_wanted;
  logic [31:0] seq_deadline;
  logic        seq_level;

  buzz_result_t pending_results[$];
  int           mismatches;
  int           words_seen;
  bit           src_steady;
  bit           sink_steady;

  buzzer_pattern_sequencer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic clear_sequencer();
    seq_playing  = 1'b0;
    seq_step     = '0;
    seq_done     = '0;
    seq_wanted   = '0;
    seq_deadline = '0;
    seq_level    = 1'b0;
  endtask

  // Works out the result of one accepted word and queues it.
  task automatic predict_word(opcode_t op, logic [31:0] now, logic [7:0] rep);
    buzz_result_t res;
    logic [31:0]  diff;
    int unsigned  pos;
    logic         accepted;
    accepted = 1'b0;
    case (op)
      OP_TICK: begin
        // catch up one step per pass until the deadline lies ahead
        while (seq_playing) begin
          diff = now - seq_deadline;
          if (diff[31]) break;
          pos = seq_step + 1;
          if (pos >= ENV_STEPS) begin
            pos = 0;
            seq_done = seq_done + 8'd1;
            if (seq_done >= seq_wanted) begin
              clear_sequencer();
              break;
            end
          end
          seq_step     = pos[3:0];
          seq_level    = ENV_LEVEL[seq_step];
          seq_deadline = seq_deadline + 32'(ENV_SPAN[seq_step]);
        end
      end
      OP_START: begin
        if (rep != 8'd0 && rep <= REP_LIMIT) begin
          seq_step     = '0;
          seq_done     = '0;
          seq_wanted   = rep;
          seq_playing  = 1'b1;
          seq_level    = ENV_LEVEL[0];
          seq_deadline = now + 32'(ENV_SPAN[0]);
          accepted     = 1'b1;
        end
      end
      OP_STOP: clear_sequencer();
      default: ;
    endcase
    res.buzzer_on      = seq_level;
    res.is_playing     = seq_playing;
    res.start_accepted = accepted;
    pending_results.push_back(res);
  endtask

  // Sends one word; entered and left at a falling edge.
  task automatic send_word(opcode_t op, logic [31:0] now, logic [7:0] rep);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rep, now};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    predict_word(op, now, rep);
  endtask

  // Holds the sender off until every queued result has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on output word %0d, %s: got %0d, expected %0d",
             words_seen, what, got, want);
    mismatches++;
  endtask

  // Output checker: every accepted output word against the oldest prediction.
  always @(posedge clk) begin
    buzz_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.buzzer_on)
          report_mismatch("buzzer_on", m_tdata[0], want.buzzer_on);
        if (m_tdata[1] !== want.is_playing)
          report_mismatch("is_playing", m_tdata[1], want.is_playing);
        if (m_tdata[2] !== want.start_accepted)
          report_mismatch("start_accepted", m_tdata[2], want.start_accepted);
        if (m_tdata[7:3] !== 5'd0)
          report_mismatch("padding", m_tdata[7:3], 0);
      end
      words_seen++;
    end
  end

  // Receiver: stalls at random before each output word unless sink_steady is set.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Commands while idle leave everything quiet.
  task automatic test_idle_commands();
    send_word(OP_TICK, 32'h0000_0000, 8'h00);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    send_word(OP_STOP, 32'h8000_0000, 8'h01);
  endtask

  // Repeat counts of zero and above the maximum are refused; the maximum is accepted.
  task automatic test_start_limits();
    send_word(OP_START, 32'h0000_1000, 8'd0);
    send_word(OP_START, 32'h0000_1000, 8'(REP_LIMIT + 1));
    send_word(OP_START, 32'h0000_1000, 8'hFF);
    send_word(OP_START, 32'h0000_1000, 8'(REP_LIMIT));
  endtask

  // Restart while playing, then tick on each exact deadline to the end.
  task automatic test_envelope_walk();
    send_word(OP_START, 32'h0000_5000, 8'd1);
    repeat (ENV_STEPS) send_word(OP_TICK, seq_deadline, 8'h00);
  endtask

  // Unused opcode while playing reports state; stop silences.
  task automatic test_stop_and_unused();
    send_word(OP_START, 32'h1234_5678, 8'd3);
    send_word(OP_UNUSED, 32'h1234_5700, 8'd0);
    send_word(OP_STOP, 32'h1234_5701, 8'd0);
  endtask

  // Deadline lands past the wrap of the millisecond counter.
  task automatic test_time_wrap();
    send_word(OP_START, 32'hFFFF_FFC0, 8'd1);
    send_word(OP_TICK, 32'h0000_0030, 8'h00);
  endtask

  // One tick covering the whole of a maximum-length phrase.
  task automatic test_catch_up();
    send_word(OP_START, 32'h7FFF_0000, 8'(REP_LIMIT));
    send_word(OP_TICK, 32'h7FFF_0000 + 32'(REP_LIMIT * 1530), 8'h00);
  endtask

  // Mostly well-formed phrases with random timing, some noise in between.
  task automatic test_random_traffic(int target);
    int          count;
    int          ticks;
    logic [31:0] now;
    logic [7:0]  rep;
    opcode_t     op;
    count = 0;
    while (count < target) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        now = $urandom;
        rep = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 3))
                                          : 8'($urandom_range(1, REP_LIMIT));
        send_word(OP_START, now, rep);
        count++;
        ticks = 0;
        while (seq_playing && ticks < 60 && count < target) begin
          op = OP_TICK;
          rep = 8'h00;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: now = now + $urandom_range(0, 200);
            5, 6: now = seq_deadline - $urandom_range(0, 1);
            7: now = now + $urandom_range(0, 5000);
            8: now = now - $urandom_range(0, 100);
            default: begin
              case ($urandom_range(0, 3))
                0: op = OP_STOP;
                1: op = OP_UNUSED;
                2: begin
                  op = OP_START;
                  rep = ($urandom_range(0, 1) != 0) ? 8'd0
                                                    : 8'($urandom_range(REP_LIMIT + 1, 255));
                end
                default: begin
                  op = OP_START;
                  rep = 8'($urandom_range(1, 3));
                end
              endcase
            end
          endcase
          send_word(op, now, rep);
          count++;
          ticks++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          op = opcode_t'($urandom_range(0, 3));
          // idle ticks and the unused opcode change nothing, so not counted
          if (op == OP_START || op == OP_STOP || (op == OP_TICK && seq_playing))
            count++;
          send_word(op, $urandom, 8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin
    int waited;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = OP_TICK;
    mismatches  = 0;
    words_seen  = 0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    clear_sequencer();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_start_limits();
    test_envelope_walk();
    drain_results();
    test_stop_and_unused();
    test_time_wrap();
    test_catch_up();
    drain_results();
    test_random_traffic(750);
    drain_results();

    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("words never delivered", 0, pending_results.size());
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* buzzer_pattern_sequencer_top.f */
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/buzzer_pattern_sequencer_top.sv
verif/tb_top.sv
